// ----- hdl/frame_tick_action_scheduler_core_macros.svh -----
// assertion macros used by the scheduler checker
`ifndef FRAME_TICK_ACTION_SCHEDULER_CORE_MACROS_SVH
`define FRAME_TICK_ACTION_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define FTAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FTAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ftas_pkg.sv -----
// types and constants of the frame tick action scheduler
`default_nettype none

package ftas_pkg;

  localparam int STEP_W  = 24;
  localparam int FRAME_W = 32;
  localparam int TAG_W   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_START   = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_RESTART = 3'd3;
  localparam logic [2:0] REQ_ADD     = 3'd4;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_RESTART,
    OP_ADD,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIRE,
    ST_STATUS
  } back_state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [STEP_W-1:0]  extrp_step;
    logic [FRAME_W-1:0] action_frame;
    logic [TAG_W-1:0]   action_tag;
    logic [FRAME_W-1:0] query_frames;
  } req_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [TAG_W-1:0]   fired_tag;
    logic               is_last;
    logic               is_started;
    logic [FRAME_W-1:0] frame_count;
    logic               elapsed_flag;
    logic               add_accepted;
  } res_item_t;

  typedef struct packed {
    op_t                op;
    logic [STEP_W-1:0]  step;
    logic [FRAME_W-1:0] frame;
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] query;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ftas_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module ftas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/ftas_front.sv -----
// request intake: accepts transactions and classifies them into commands
`default_nettype none

module ftas_front
  import ftas_pkg::*;
(
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      push_valid,
  input  logic      push_ready,
  output cmd_t      push_cmd
);

  op_t op;

  always_comb begin
    unique case (req_item.req_type)
      REQ_TICK:    op = OP_TICK;
      REQ_START:   op = OP_START;
      REQ_STOP:    op = OP_STOP;
      REQ_RESTART: op = OP_RESTART;
      REQ_ADD:     op = OP_ADD;
      default:     op = OP_NONE;
    endcase
  end

  assign req_ready  = push_ready;
  assign push_valid = req_valid;

  always_comb begin
    push_cmd.op    = op;
    push_cmd.step  = req_item.extrp_step;
    push_cmd.frame = req_item.action_frame;
    push_cmd.tag   = req_item.action_tag;
    push_cmd.query = req_item.query_frames;
  end

endmodule

`default_nettype wire

// ----- hdl/ftas_queue.sv -----
// short command queue between intake and execution
`default_nettype none

module ftas_queue
  import ftas_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ftas_back.sv -----
// execution engine: run state, frame counting, action table scan, result register
`default_nettype none

module ftas_back
  import ftas_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  cmd_t      pop_cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int WHOLE_W = SUM_W - FRAC_BITS;
  localparam int ENT_W   = 1 + FRAME_W + TAG_W;

  back_state_t state, state_next;

  cmd_t                 cmd;
  logic                 run_flag;
  logic [FRAC_BITS-1:0] frac_accum;
  logic [FRAME_W-1:0]   frame_counter;
  logic [FRAME_W-1:0]   old_frame;
  logic [CNT_W-1:0]     used;
  logic                 accepted;

  logic [CNT_W-1:0]     rd_idx;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  logic [FRAME_W:0]     best_eff;
  logic [FRAME_W-1:0]   best_target;
  logic [TAG_W-1:0]     best_id;

  logic [SUM_W-1:0]     sum;
  logic [WHOLE_W-1:0]   whole;
  logic [FRAME_W:0]     nf_wide;
  logic [FRAME_W-1:0]   nf;
  logic                 has_room;
  logic                 res_free;
  logic                 scan_done;
  logic                 elapsed;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  logic                 ent_done;
  logic [FRAME_W-1:0]   ent_target;
  logic [TAG_W-1:0]     ent_id;
  logic                 ent_elig;
  logic [FRAME_W:0]     ent_eff;
  logic                 ent_better;

  logic                 load_res;
  res_item_t            res_next;

  ftas_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // tick arithmetic
  assign sum      = SUM_W'(frac_accum) + SUM_W'(cmd.step);
  assign whole    = sum[SUM_W-1:FRAC_BITS];
  assign nf_wide  = {1'b0, frame_counter} + (FRAME_W + 1)'(whole);
  assign nf       = nf_wide[FRAME_W] ? '1 : nf_wide[FRAME_W-1:0];
  assign has_room = (used < CNT_W'(MAX_SLOTS));

  // table entry under evaluation
  assign ent_done   = ram_rdata[ENT_W-1];
  assign ent_target = ram_rdata[ENT_W-2 -: FRAME_W];
  assign ent_id     = ram_rdata[TAG_W-1:0];
  assign ent_elig   = !ent_done && (ent_target <= frame_counter);
  assign ent_eff    = (ent_target <= old_frame) ? ({1'b0, old_frame} + 1'b1)
                                                : {1'b0, ent_target};
  assign ent_better = pend && ent_elig && (!best_found || (ent_eff < best_eff));

  assign scan_done = (rd_idx == used) && !pend;
  assign res_free  = !res_valid || res_ready;
  assign elapsed   = run_flag && (frame_counter >= cmd.query);
  assign pop_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = best_idx;
    ram_wdata  = {1'b1, best_target, best_id};
    load_res   = 1'b0;
    res_next.result_kind  = KIND_STATUS;
    res_next.fired_tag    = '0;
    res_next.is_last      = 1'b1;
    res_next.is_started   = run_flag;
    res_next.frame_count  = frame_counter;
    res_next.elapsed_flag = elapsed;
    res_next.add_accepted = accepted;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.op == OP_ADD && has_room) begin
          ram_we    = 1'b1;
          ram_waddr = used[IDX_W-1:0];
          ram_wdata = {1'b0, cmd.frame, cmd.tag};
        end
        if (cmd.op == OP_TICK && run_flag && whole != '0) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_STATUS;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = best_found ? ST_FIRE : ST_STATUS;
        end
      end
      ST_FIRE: begin
        res_next.result_kind  = KIND_FIRED;
        res_next.fired_tag    = best_id;
        res_next.is_last      = 1'b0;
        res_next.add_accepted = 1'b0;
        if (res_free) begin
          load_res   = 1'b1;
          ram_we     = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_STATUS: begin
        if (res_free) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // command register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      cmd <= pop_cmd;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag      <= 1'b0;
      frac_accum    <= '0;
      frame_counter <= '0;
      used          <= '0;
      accepted      <= 1'b0;
    end else if (state == ST_IDLE && pop_valid) begin
      accepted <= 1'b0;
    end else if (state == ST_EXEC) begin
      unique case (cmd.op)
        OP_TICK: begin
          if (run_flag) begin
            frac_accum    <= sum[FRAC_BITS-1:0];
            frame_counter <= nf;
          end
        end
        OP_START: begin
          run_flag <= 1'b1;
        end
        OP_STOP: begin
          run_flag      <= 1'b0;
          frac_accum    <= '0;
          frame_counter <= '0;
          used          <= '0;
        end
        OP_RESTART: begin
          run_flag      <= 1'b1;
          frac_accum    <= '0;
          frame_counter <= '0;
          used          <= '0;
        end
        OP_ADD: begin
          if (has_room) begin
            used     <= used + 1'b1;
            accepted <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      old_frame <= frame_counter;
    end
  end

  // table scan, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      pend       <= 1'b0;
      best_found <= 1'b0;
    end else if (state != ST_SCAN) begin
      rd_idx     <= '0;
      pend       <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (rd_idx < used) begin
        rd_idx <= rd_idx + 1'b1;
        pend   <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (ent_better) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= rd_idx[IDX_W-1:0];
    if (state == ST_SCAN && ent_better) begin
      best_idx    <= pend_idx;
      best_eff    <= ent_eff;
      best_target <= ent_target;
      best_id     <= ent_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_item <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/frame_tick_action_scheduler_core.sv -----
// top level of the frame tick action scheduler
// a non-tick request goes through the EXEC and STATUS states; its status result is registered
// a tick that advances the frame scans the stored actions once per firing and once more,
//   in a table scan that reads one slot per cycle from the action ram
// the engine takes a new request only in its idle state; two more can wait in the queue
// reset: synchronous, clears run flag, accumulator, frame counter and table fill
`default_nettype none

module frame_tick_action_scheduler_core
  import ftas_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  ftas_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_item   (req_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ftas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ftas_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
`default_nettype wire

// ----- hdl/ftas_checker.sv -----
// port-level checker for the scheduler, bound to the top level
`default_nettype none
`include "frame_tick_action_scheduler_core_macros.svh"

module ftas_checker
  import ftas_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input req_item_t req_item,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_item
);

  `FTAS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready,
                    req_valid && $stable(req_item), "request changed while stalled")
  `FTAS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
                    res_valid && $stable(res_item), "result changed while stalled")
  `FTAS_ASSERT_NOW(a_last_is_status, res_valid,
                   res_item.is_last == (res_item.result_kind == KIND_STATUS),
                   "last flag and kind disagree")
  `FTAS_ASSERT_NOW(a_elapsed_running, res_valid && res_item.elapsed_flag,
                   res_item.is_started, "elapsed while stopped")
  `FTAS_ASSERT_NOW(a_add_on_status, res_valid && res_item.add_accepted,
                   res_item.is_last && res_item.fired_tag == '0,
                   "add flag on fired transaction")

endmodule

bind frame_tick_action_scheduler_core ftas_checker u_ftas_checker (.*);

`default_nettype wire
